// ----- rtl/lmpc_pkg.sv -----
package lmpc_pkg;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_LOCKOUT_MS = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLINK_MS   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FADE_MS    = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FADE_STEP  = 8'd3;

  localparam logic [15:0] LOCKOUT_MS_RST = 16'd300;
  localparam logic [15:0] BLINK_MS_RST   = 16'd150;
  localparam logic [15:0] FADE_MS_RST    = 16'd10;
  localparam logic [7:0]  FADE_STEP_RST  = 8'd5;

  localparam logic [2:0] MODE_OFF   = 3'd1;
  localparam logic [2:0] MODE_BLINK = 3'd2;
  localparam logic [2:0] MODE_ON    = 3'd3;
  localparam logic [2:0] MODE_FADE  = 3'd4;

  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
  localparam logic [7:0]  DUTY_FULL  = 8'd255;
  localparam logic [7:0]  DUTY_OFF   = 8'd0;
  localparam logic [7:0]  FADE_BIAS  = 8'd50;
  localparam logic [1:0]  LIT_LAST   = 2'd2;

  typedef struct packed {
    logic mode_button;
    logic reset_button;
  } lmpc_in_t;

  typedef struct packed {
    logic [7:0] duty_one;
    logic [7:0] duty_two;
    logic [7:0] duty_three;
    logic [2:0] mode_now;
  } lmpc_out_t;

endpackage

// ----- rtl/led_mode_pattern_controller.sv -----
// LED mode pattern controller.
// Each beat on the input channel is one millisecond tick carrying the levels
// of the active-low mode and reset buttons. Each accepted tick yields exactly
// one beat on the output channel: three LED PWM duties and the current mode.
// The configuration channel writes lockout_ms, blink_ms, fade_ms and
// fade_step by index; writes to other indexes are dropped. It is always ready
// and should only be used while no tick is in flight.
// The tick updates all state at the accepting edge and its result is visible on
// the output register in the next cycle.
// Throughput is one tick per cycle. The only limit is the single output
// register: a tick is accepted when that register is empty or is being
// drained in the same cycle.
// When the receiver stalls, the result is held in the output register and
// the input ready drops until it is taken.
// Synchronous reset restores the register defaults, mode 1 (all off), both
// buttons released, zero counters and duties, a rising fade direction, and
// empties the output register.
module led_mode_pattern_controller (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  lmpc_pkg::lmpc_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output lmpc_pkg::lmpc_out_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lmpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lmpc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lmpc_pkg::*;

  logic [15:0] lockout_ms;
  logic [15:0] blink_ms;
  logic [15:0] fade_ms;
  logic [7:0]  fade_step;

  logic [2:0]  mode_reg;
  logic        prev_mode_level;
  logic        prev_reset_level;
  logic [15:0] since_press;
  logic [15:0] since_pattern_step;
  logic [7:0]  fade_level;
  logic        fade_rising;
  logic [1:0]  lit_index;
  logic [7:0]  held_duty [3];

  logic [2:0]  mode_reg_next;
  logic [15:0] since_press_next;
  logic [15:0] since_pattern_step_next;
  logic [7:0]  fade_level_next;
  logic        fade_rising_next;
  logic [1:0]  lit_index_next;
  logic [7:0]  held_duty_next [3];

  logic        accept;
  logic [15:0] press_count;
  logic [15:0] step_count;
  logic        mode_hit;
  logic        reset_hit;
  logic [8:0]  level_up;
  logic [7:0]  level_moved;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_ms <= LOCKOUT_MS_RST;
      blink_ms   <= BLINK_MS_RST;
      fade_ms    <= FADE_MS_RST;
      fade_step  <= FADE_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOCKOUT_MS: lockout_ms <= cfg_data;
        REG_BLINK_MS:   blink_ms   <= cfg_data;
        REG_FADE_MS:    fade_ms    <= cfg_data;
        REG_FADE_STEP:  fade_step  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    press_count = (since_press == COUNT_MAX) ? since_press : since_press + 16'd1;
    step_count  = (since_pattern_step == COUNT_MAX) ? since_pattern_step
                                                    : since_pattern_step + 16'd1;

    // A mode press clears the elapsed count and locks out a reset press
    // falling in the same tick.
    mode_hit  = !in_data.mode_button && prev_mode_level && (press_count > lockout_ms);
    reset_hit = !in_data.reset_button && prev_reset_level && (press_count > lockout_ms)
                && !mode_hit;

    mode_reg_next = mode_reg;
    if (mode_hit) begin
      mode_reg_next = (mode_reg >= MODE_FADE) ? MODE_OFF : mode_reg + 3'd1;
    end else if (reset_hit) begin
      mode_reg_next = MODE_OFF;
    end
    since_press_next = (mode_hit || reset_hit) ? 16'd0 : press_count;

    // Fade level moves by the step and clamps to the 8-bit range.
    level_up = {1'b0, fade_level} + {1'b0, fade_step};
    if (fade_rising) begin
      level_moved = level_up[8] ? DUTY_FULL : level_up[7:0];
    end else begin
      level_moved = (fade_step > fade_level) ? DUTY_OFF : fade_level - fade_step;
    end

    since_pattern_step_next = step_count;
    fade_level_next         = fade_level;
    fade_rising_next        = fade_rising;
    lit_index_next          = lit_index;
    for (int i = 0; i < 3; i++) begin
      held_duty_next[i] = held_duty[i];
    end

    case (mode_reg_next)
      MODE_BLINK: begin
        if (step_count >= blink_ms) begin
          lit_index_next = (lit_index == LIT_LAST) ? 2'd0 : lit_index + 2'd1;
          for (int i = 0; i < 3; i++) begin
            held_duty_next[i] = (lit_index_next == 2'(i)) ? DUTY_FULL : DUTY_OFF;
          end
          since_pattern_step_next = 16'd0;
        end
      end
      MODE_ON: begin
        for (int i = 0; i < 3; i++) begin
          held_duty_next[i] = DUTY_FULL;
        end
      end
      MODE_FADE: begin
        if (step_count >= fade_ms) begin
          fade_level_next = level_moved;
          if (level_moved == DUTY_FULL || level_moved == DUTY_OFF) begin
            fade_rising_next = !fade_rising;
          end
          held_duty_next[0] = level_moved;
          held_duty_next[1] = DUTY_FULL - level_moved;
          held_duty_next[2] = {1'b0, level_moved[7:1]} + FADE_BIAS;
          since_pattern_step_next = 16'd0;
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          held_duty_next[i] = DUTY_OFF;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg           <= MODE_OFF;
      prev_mode_level    <= 1'b1;
      prev_reset_level   <= 1'b1;
      since_press        <= 16'd0;
      since_pattern_step <= 16'd0;
      fade_level         <= 8'd0;
      fade_rising        <= 1'b1;
      lit_index          <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        held_duty[i] <= DUTY_OFF;
      end
    end else if (accept) begin
      mode_reg           <= mode_reg_next;
      prev_mode_level    <= in_data.mode_button;
      prev_reset_level   <= in_data.reset_button;
      since_press        <= since_press_next;
      since_pattern_step <= since_pattern_step_next;
      fade_level         <= fade_level_next;
      fade_rising        <= fade_rising_next;
      lit_index          <= lit_index_next;
      for (int i = 0; i < 3; i++) begin
        held_duty[i] <= held_duty_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.duty_one   <= held_duty_next[0];
      out_data.duty_two   <= held_duty_next[1];
      out_data.duty_three <= held_duty_next[2];
      out_data.mode_now   <= mode_reg_next;
    end
  end

`ifndef ASSERT_OFF
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    mode_reg >= MODE_OFF && mode_reg <= MODE_FADE)
    else $error("mode register left the range 1 to 4");

  a_mode_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(mode_reg))
    else $error("mode changed without an accepted tick");

  a_result_follows_tick: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid && out_data.mode_now == mode_reg)
    else $error("accepted tick did not produce a matching result beat");

  a_on_mode_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.mode_now == MODE_ON |->
      out_data.duty_one == DUTY_FULL && out_data.duty_two == DUTY_FULL &&
      out_data.duty_three == DUTY_FULL)
    else $error("all-on mode result without full duties");
`endif

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
  import lmpc_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED    = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_TOP = 8'hFF;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int MAX_GAP = 20;

  class duty_tracker;
    lmpc_out_t pending_duties[$];
    int errors = 0;
    int checked = 0;

    function void note_tick(lmpc_out_t want);
      pending_duties.push_back(want);
    endfunction

    function int pending();
      return pending_duties.size();
    endfunction

    function void check_duties(lmpc_out_t got);
      lmpc_out_t want;
      if (pending_duties.size() == 0) begin
        $display("%0t: result beat with no tick pending: expected none, got %p", $time, got);
        errors++;
        return;
      end
      want = pending_duties.pop_front();
      checked++;
      if (got.duty_one !== want.duty_one) begin
        $display("%0t: duty_one expected %0d, got %0d", $time, want.duty_one, got.duty_one);
        errors++;
      end
      if (got.duty_two !== want.duty_two) begin
        $display("%0t: duty_two expected %0d, got %0d", $time, want.duty_two, got.duty_two);
        errors++;
      end
      if (got.duty_three !== want.duty_three) begin
        $display("%0t: duty_three expected %0d, got %0d", $time, want.duty_three,
                 got.duty_three);
        errors++;
      end
      if (got.mode_now !== want.mode_now) begin
        $display("%0t: mode_now expected %0d, got %0d", $time, want.mode_now, got.mode_now);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  lmpc_in_t in_data = '1;
  logic out_valid;
  logic out_ready = 1'b0;
  lmpc_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  led_mode_pattern_controller uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  duty_tracker board;

  // Expected register and state contents, as left by reset.
  logic [15:0] lock_ms  = LOCKOUT_MS_RST;
  logic [15:0] blink_ms = BLINK_MS_RST;
  logic [15:0] fade_ms  = FADE_MS_RST;
  logic [7:0]  fade_inc = FADE_STEP_RST;
  logic [2:0]  mode_reg = MODE_OFF;
  logic        last_mode_lvl = 1'b1;
  logic        last_reset_lvl = 1'b1;
  logic [15:0] since_press = '0;
  logic [15:0] since_step = '0;
  logic [7:0]  fade_level = '0;
  logic        fade_rising = 1'b1;
  logic [1:0]  lit_index = '0;
  logic [7:0]  held [3] = '{DUTY_OFF, DUTY_OFF, DUTY_OFF};

  int presses = 0;
  int rotations = 0;
  int fade_steps = 0;
  int ticks_sent = 0;
  int settings_used = 1;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stalls_asked = 0;
  int stalls_done = 0;
  int stall_left = 0;

  logic mode_lvl = 1'b1;
  logic reset_lvl = 1'b1;

  // Advances the expected state by one millisecond tick and returns the duties it leaves.
  function automatic lmpc_out_t next_duties(lmpc_in_t t);
    int lvl;
    lmpc_out_t res;
    if (since_press != COUNT_MAX) since_press++;
    if (since_step != COUNT_MAX) since_step++;
    if (!t.mode_button && last_mode_lvl && since_press > lock_ms) begin
      mode_reg = (mode_reg == MODE_FADE) ? MODE_OFF : mode_reg + 3'd1;
      since_press = '0;
      presses++;
    end
    // A mode press in the same tick has just cleared since_press, which locks this out.
    if (!t.reset_button && last_reset_lvl && since_press > lock_ms) begin
      mode_reg = MODE_OFF;
      since_press = '0;
      presses++;
    end
    last_mode_lvl = t.mode_button;
    last_reset_lvl = t.reset_button;
    case (mode_reg)
      MODE_OFF: held = '{DUTY_OFF, DUTY_OFF, DUTY_OFF};
      MODE_BLINK: begin
        if (since_step >= blink_ms) begin
          lit_index = (lit_index == LIT_LAST) ? 2'd0 : lit_index + 2'd1;
          held = '{DUTY_OFF, DUTY_OFF, DUTY_OFF};
          held[lit_index] = DUTY_FULL;
          since_step = '0;
          rotations++;
        end
      end
      MODE_ON: held = '{DUTY_FULL, DUTY_FULL, DUTY_FULL};
      MODE_FADE: begin
        if (since_step >= fade_ms) begin
          lvl = fade_rising ? int'(fade_level) + int'(fade_inc)
                            : int'(fade_level) - int'(fade_inc);
          if (lvl > 255) lvl = 255;
          if (lvl < 0) lvl = 0;
          fade_level = lvl[7:0];
          if (fade_level == DUTY_FULL || fade_level == DUTY_OFF) fade_rising = !fade_rising;
          held[0] = fade_level;
          held[1] = DUTY_FULL - fade_level;
          held[2] = (fade_level >> 1) + FADE_BIAS;
          since_step = '0;
          fade_steps++;
        end
      end
      default: ;
    endcase
    res.duty_one = held[0];
    res.duty_two = held[1];
    res.duty_three = held[2];
    res.mode_now = mode_reg;
    return res;
  endfunction

  // Receiver: random back-pressure, plus a long hold-off whenever one is asked for.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_done != stalls_asked) begin
      out_ready <= 1'b0;
      stall_left <= HOLD_OFF_CYCLES;
      stalls_done <= stalls_done + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Handshake signals settle well before the falling edge, so a beat seen here
  // is the one taken at the next rising edge.
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) board.check_duties(out_data);
  end

  // Called at a rising edge; returns at the rising edge that takes the beat.
  task automatic send_tick(input lmpc_in_t t);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    board.note_tick(next_duties(t));
    ticks_sent++;
    @(posedge clk);
  endtask

  task automatic tick(input logic mb, input logic rb);
    lmpc_in_t t;
    t.mode_button = mb;
    t.reset_button = rb;
    send_tick(t);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    case (idx)
      REG_LOCKOUT_MS: lock_ms = val;
      REG_BLINK_MS:   blink_ms = val;
      REG_FADE_MS:    fade_ms = val;
      REG_FADE_STEP:  fade_inc = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // The upper byte of the fade step write is junk that the block must drop.
  task automatic apply_settings(input logic [15:0] lock, input logic [15:0] blink,
                                input logic [15:0] fade, input logic [7:0] step);
    drain();
    write_reg(REG_LOCKOUT_MS, lock);
    write_reg(REG_BLINK_MS, blink);
    write_reg(REG_FADE_MS, fade);
    write_reg(REG_FADE_STEP, {8'($urandom), step});
    settings_used++;
  endtask

  task automatic set_idling(input int profile);
    case (profile)
      0: begin send_idle_pct = 10; recv_idle_pct = 50; end
      1: begin send_idle_pct = 50; recv_idle_pct = 10; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  // Button levels wander as press pulses of random length, with some noise.
  task automatic random_ticks(input int n, input int press_pct, input bit pause_mid,
                              input bit hold_mid);
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2 && board.pending() != 0) begin
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
      end
      if (hold_mid && i == n / 2) stalls_asked++;
      if ($urandom_range(99) < 4) begin
        mode_lvl = 1'($urandom_range(1));
        reset_lvl = 1'($urandom_range(1));
      end else begin
        mode_lvl = mode_lvl ? ($urandom_range(99) >= press_pct) : ($urandom_range(99) < 50);
        reset_lvl = reset_lvl ? ($urandom_range(99) >= press_pct / 2)
                              : ($urandom_range(99) < 50);
      end
      tick(mode_lvl, reset_lvl);
    end
  endtask

  task automatic random_phase(input int p);
    logic [7:0] step;
    case ($urandom_range(3))
      0: step = 8'd0;
      1: step = 8'd1;
      2: step = DUTY_FULL;
      default: step = 8'($urandom_range(2, 254));
    endcase
    apply_settings(16'($urandom_range(0, 25)), 16'($urandom_range(0, 8)),
                   16'($urandom_range(0, 4)), step);
    set_idling(p < 2 ? 0 : (p < 5 ? 1 : 2));
    random_ticks(100, 15, p == 2, p == 5);
  endtask

  initial begin
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Settings as they come out of reset.
    set_idling(0);
    random_ticks(150, 3, 1'b0, 1'b0);

    // Short lockout, fastest pattern and the full fade step.
    apply_settings(16'd0, 16'd1, 16'd1, DUTY_FULL);
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(REG_INDEX_TOP, 16'd0);
    tick(1, 1);
    tick(0, 1);
    tick(0, 1);
    tick(1, 1);
    tick(0, 1);
    tick(1, 1);
    tick(0, 1);
    tick(1, 1);
    tick(1, 1);
    tick(1, 1);
    tick(0, 1);
    tick(1, 0);
    tick(1, 1);
    tick(0, 0);
    tick(1, 1);
    tick(1, 0);
    tick(1, 1);
    tick(0, 1);
    tick(1, 1);
    tick(1, 1);

    // Zero intervals and a zero fade step: steps every tick, level stuck at an end.
    apply_settings(16'd0, 16'd0, 16'd0, 8'd0);
    tick(0, 1);
    tick(1, 1);
    tick(0, 1);
    tick(1, 1);
    tick(1, 1);

    random_phase(0);
    random_phase(1);
    random_phase(2);
    random_phase(3);

    // Get into blink mode, then run with the widest settings: every press here
    // stays locked out and no pattern step comes due.
    apply_settings(16'd0, 16'd1, 16'd1, 8'd1);
    tick(1, 1);
    tick(1, 0);
    tick(1, 1);
    tick(0, 1);
    tick(1, 1);
    apply_settings(COUNT_MAX, COUNT_MAX, COUNT_MAX, 8'd1);
    for (int i = 0; i < 200; i++) tick(i % 37 != 5, i % 53 != 11);

    random_phase(4);
    random_phase(5);
    random_phase(6);
    random_phase(7);

    drain();
    $display("Ran %0d ticks (%0d results checked) over %0d register settings:",
             ticks_sent, board.checked, settings_used);
    $display("  %0d presses taken, %0d blink rotations, %0d fade steps.",
             presses, rotations, fade_steps);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("led_mode_pattern_controller test passed");
    end else begin
      $display("led_mode_pattern_controller test failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("led_mode_pattern_controller test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/lmpc_pkg.sv
rtl/led_mode_pattern_controller.sv
bench/tb_top.sv
